FILE: sv/tro_pkg.sv
`default_nettype none
package tro_pkg;

   localparam int OPTION_COUNT = 256;
   localparam int OPT_AW       = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;
   localparam int ENTRY_W      = 6;

   localparam logic [7:0] CMD_IAC  = 8'hFF;
   localparam logic [7:0] CMD_DONT = 8'hFE;
   localparam logic [7:0] CMD_DO   = 8'hFD;
   localparam logic [7:0] CMD_WONT = 8'hFC;
   localparam logic [7:0] CMD_WILL = 8'hFB;
   localparam logic [7:0] CMD_SB   = 8'hFA;
   localparam logic [7:0] CMD_SE   = 8'hF0;

   localparam logic [1:0] V_DO   = 2'd0;
   localparam logic [1:0] V_DONT = 2'd1;
   localparam logic [1:0] V_WILL = 2'd2;
   localparam logic [1:0] V_WONT = 2'd3;

   localparam logic [2:0] S_NO          = 3'd0;
   localparam logic [2:0] S_WANTNO      = 3'd1;
   localparam logic [2:0] S_WANTNO_OPP  = 3'd2;
   localparam logic [2:0] S_WANTYES     = 3'd3;
   localparam logic [2:0] S_WANTYES_OPP = 3'd4;
   localparam logic [2:0] S_YES         = 3'd5;

   localparam logic OUT_DATA  = 1'b0;
   localparam logic OUT_REPLY = 1'b1;

   typedef enum logic [4:0] {
      P_DATA    = 5'b00001,
      P_IAC     = 5'b00010,
      P_VERB    = 5'b00100,
      P_SUB     = 5'b01000,
      P_SUB_IAC = 5'b10000
   } parse_state_type;

   // work handed from the parser to the table stage
   typedef struct packed {
      logic       vld;
      logic       is_nego;
      logic [7:0] ch;
      logic [1:0] verb;
   } item_type;

   typedef struct packed {
      logic               emit;
      logic [1:0]         verb;
      logic               wr_en;
      logic [ENTRY_W-1:0] entry;
   } nego_type;

   function automatic logic opt_in_range(input logic [7:0] opt);
      return {1'b0, opt} < 9'(OPTION_COUNT);
   endfunction

endpackage
`default_nettype wire

FILE: sv/tro_parser.sv
`default_nettype none
module tro_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [7:0]                 rx_byte,
   output tro_pkg::item_type               item,
   output logic                            rd_en,
   output logic [tro_pkg::OPT_AW-1:0]      rd_addr
);

   tro_pkg::parse_state_type state_ff, state_in;
   logic [1:0]               pverb_ff, pverb_in;

   always_comb begin
      state_in     = state_ff;
      pverb_in     = pverb_ff;
      item.vld     = 1'b0;
      item.is_nego = 1'b0;
      item.ch      = rx_byte;
      item.verb    = pverb_ff;
      case (state_ff)
         tro_pkg::P_IAC: begin
            state_in = tro_pkg::P_DATA;
            if (rx_byte == tro_pkg::CMD_IAC) begin
               item.vld = 1'b1;
            end else if (rx_byte == tro_pkg::CMD_DO) begin
               pverb_in = tro_pkg::V_DO;
               state_in = tro_pkg::P_VERB;
            end else if (rx_byte == tro_pkg::CMD_DONT) begin
               pverb_in = tro_pkg::V_DONT;
               state_in = tro_pkg::P_VERB;
            end else if (rx_byte == tro_pkg::CMD_WILL) begin
               pverb_in = tro_pkg::V_WILL;
               state_in = tro_pkg::P_VERB;
            end else if (rx_byte == tro_pkg::CMD_WONT) begin
               pverb_in = tro_pkg::V_WONT;
               state_in = tro_pkg::P_VERB;
            end else if (rx_byte == tro_pkg::CMD_SB) begin
               state_in = tro_pkg::P_SUB;
            end
         end
         tro_pkg::P_VERB: begin
            state_in     = tro_pkg::P_DATA;
            item.vld     = 1'b1;
            item.is_nego = 1'b1;
         end
         tro_pkg::P_SUB: begin
            if (rx_byte == tro_pkg::CMD_IAC) begin
               state_in = tro_pkg::P_SUB_IAC;
            end
         end
         tro_pkg::P_SUB_IAC: begin
            state_in = (rx_byte == tro_pkg::CMD_SE) ? tro_pkg::P_DATA : tro_pkg::P_SUB;
         end
         default: begin
            if (rx_byte == tro_pkg::CMD_IAC) begin
               state_in = tro_pkg::P_IAC;
            end else begin
               state_in = tro_pkg::P_DATA;
               item.vld = 1'b1;
            end
         end
      endcase
   end

   assign rd_en   = accept && (state_ff == tro_pkg::P_VERB) && tro_pkg::opt_in_range(rx_byte);
   assign rd_addr = tro_pkg::OPT_AW'(rx_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tro_pkg::P_DATA;
         pverb_ff <= tro_pkg::V_DO;
      end else if (accept) begin
         state_ff <= state_in;
         pverb_ff <= pverb_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/tro_opt_table.sv
`default_nettype none
module tro_opt_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [tro_pkg::OPT_AW-1:0]    rd_addr,
   output logic [tro_pkg::ENTRY_W-1:0]        rd_entry,
   input  wire logic                          wr_en,
   input  wire logic [tro_pkg::OPT_AW-1:0]    wr_addr,
   input  wire logic [tro_pkg::ENTRY_W-1:0]   wr_data
);

   logic [tro_pkg::ENTRY_W-1:0]      mem [tro_pkg::OPTION_COUNT];
   logic [tro_pkg::OPTION_COUNT-1:0] vld_ff;
   logic [tro_pkg::ENTRY_W-1:0]      rd_data_ff;
   logic                             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
      end
   end

   // per-entry valid bits; an entry never written reads as NO/NO
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr] || (wr_en && (wr_addr == rd_addr));
         end
      end
   end

   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

FILE: sv/tro_nego.sv
`default_nettype none
module tro_nego (
   input  wire logic [1:0]                  verb,
   input  wire logic                        in_range,
   input  wire logic                        accept_req,
   input  wire logic [tro_pkg::ENTRY_W-1:0] entry,
   output tro_pkg::nego_type                res
);

   logic       remote;
   logic       want_on;
   logic [1:0] pos_reply;
   logic [1:0] neg_reply;
   logic [2:0] side;
   logic [2:0] next;

   assign remote    = (verb == tro_pkg::V_WILL) || (verb == tro_pkg::V_WONT);
   assign want_on   = (verb == tro_pkg::V_DO) || (verb == tro_pkg::V_WILL);
   assign pos_reply = remote ? tro_pkg::V_DO : tro_pkg::V_WILL;
   assign neg_reply = remote ? tro_pkg::V_DONT : tro_pkg::V_WONT;
   assign side      = remote ? entry[5:3] : entry[2:0];

   always_comb begin
      res.emit  = 1'b0;
      res.verb  = neg_reply;
      res.wr_en = 1'b0;
      next      = side;
      if (!in_range) begin
         res.emit = want_on;
      end else begin
         case (side)
            tro_pkg::S_YES: begin
               if (!want_on) begin
                  next      = tro_pkg::S_NO;
                  res.emit  = 1'b1;
                  res.wr_en = 1'b1;
               end
            end
            tro_pkg::S_NO: begin
               if (want_on) begin
                  res.emit  = 1'b1;
                  res.wr_en = 1'b1;
                  if (accept_req) begin
                     next     = tro_pkg::S_YES;
                     res.verb = pos_reply;
                  end
               end
            end
            tro_pkg::S_WANTNO: begin
               next      = tro_pkg::S_NO;
               res.wr_en = 1'b1;
            end
            tro_pkg::S_WANTNO_OPP: begin
               next      = tro_pkg::S_WANTYES;
               res.emit  = 1'b1;
               res.verb  = pos_reply;
               res.wr_en = 1'b1;
            end
            tro_pkg::S_WANTYES: begin
               next      = want_on ? tro_pkg::S_YES : tro_pkg::S_NO;
               res.wr_en = 1'b1;
            end
            tro_pkg::S_WANTYES_OPP: begin
               res.wr_en = 1'b1;
               if (want_on) begin
                  next     = tro_pkg::S_WANTNO;
                  res.emit = 1'b1;
               end else begin
                  next = tro_pkg::S_NO;
               end
            end
            default: begin
               next = side;
            end
         endcase
      end
      res.entry = remote ? {next, entry[2:0]} : {entry[5:3], next};
   end

endmodule
`default_nettype wire

FILE: sv/telnet_rx_option_negotiator.sv
`default_nettype none
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_rx_byte, req_chunk_last
// rsp       out        rsp_valid/rsp_stall  rsp_out_kind, rsp_data_byte,
//                                           rsp_reply_verb, rsp_reply_option
// csr       in         csr_valid/csr_ready  csr_accept_requests
//
// One byte per cycle while req_stall is low. Parser stage reads the option
// table (sync RAM), the next stage does the read-modify-write and loads the
// output register: rsp_valid rises once a result moves from s1_ff into it.
// Reset (sync) clears parser state and table valid bits. rsp_stall backs up
// through the output register into req_stall; no transfer is lost.
module telnet_rx_option_negotiator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_chunk_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_out_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [1:0]      rsp_reply_verb,
   output logic [7:0]      rsp_reply_option,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_accept_requests
);

   logic                          accept;
   tro_pkg::item_type             item;
   logic                          rd_en;
   logic [tro_pkg::OPT_AW-1:0]    rd_addr;
   logic [tro_pkg::ENTRY_W-1:0]   rd_entry;
   tro_pkg::nego_type             nego;

   logic                          acc_req_ff;
   tro_pkg::item_type             s1_ff;
   logic                          s1_adv;
   logic                          s1_in_range;
   logic                          has_result;
   logic                          tbl_we;

   logic                          out_vld_ff;
   logic                          out_kind_ff, out_kind_in;
   logic [7:0]                    out_data_ff, out_data_in;
   logic [1:0]                    out_verb_ff, out_verb_in;
   logic [7:0]                    out_opt_ff, out_opt_in;

   assign s1_adv    = s1_ff.vld && (!out_vld_ff || !rsp_stall);
   assign req_stall = s1_ff.vld && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   tro_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .item    (item),
      .rd_en   (rd_en),
      .rd_addr (rd_addr)
   );

   assign s1_in_range = tro_pkg::opt_in_range(s1_ff.ch);

   tro_nego u_nego (
      .verb       (s1_ff.verb),
      .in_range   (s1_in_range),
      .accept_req (acc_req_ff),
      .entry      (rd_entry),
      .res        (nego)
   );

   assign tbl_we = s1_adv && s1_ff.is_nego && s1_in_range && nego.wr_en;

   tro_opt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (tbl_we),
      .wr_addr  (tro_pkg::OPT_AW'(s1_ff.ch)),
      .wr_data  (nego.entry)
   );

   always_comb begin
      has_result = s1_ff.is_nego ? nego.emit : 1'b1;
      if (s1_ff.is_nego) begin
         out_kind_in = tro_pkg::OUT_REPLY;
         out_data_in = 8'd0;
         out_verb_in = nego.verb;
         out_opt_in  = s1_ff.ch;
      end else begin
         out_kind_in = tro_pkg::OUT_DATA;
         out_data_in = s1_ff.ch;
         out_verb_in = tro_pkg::V_DO;
         out_opt_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_req_ff <= 1'b0;
         s1_ff.vld  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            acc_req_ff <= csr_accept_requests;
         end
         if (accept) begin
            s1_ff.vld <= item.vld;
         end else if (s1_adv) begin
            s1_ff.vld <= 1'b0;
         end
         if (s1_adv) begin
            out_vld_ff <= has_result;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_ff.is_nego <= item.is_nego;
         s1_ff.ch      <= item.ch;
         s1_ff.verb    <= item.verb;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_verb_ff <= out_verb_in;
         out_opt_ff  <= out_opt_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_reply_verb   = out_verb_ff;
   assign rsp_reply_option = out_opt_ff;

endmodule
`default_nettype wire

FILE: tb/telnet_rx_checker.sv
module telnet_rx_checker
   import tro_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic       rsp_out_kind,
   input  wire logic [7:0] rsp_data_byte,
   input  wire logic [1:0] rsp_reply_verb,
   input  wire logic [7:0] rsp_reply_option,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic       csr_accept_requests,
   output int              mismatches,
   output int              outstanding,
   output int              bytes_seen,
   output int              data_seen,
   output int              replies_seen,
   output int              stall_cycles
);

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [1:0] verb;
      logic [7:0] opt;
   } rx_result_type;

   rx_result_type   expected_q[$];
   parse_state_type parse_q;
   logic [1:0]      verb_q;
   logic            accept_q;
   logic [5:0]      opt_state [OPTION_COUNT];

   task automatic report(input string msg);
      mismatches++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   // RFC 1143 table update for one peer request
   function automatic bit run_option(input logic [1:0] verb, input logic [7:0] opt,
                                     output rx_result_type res);
      logic       remote, want_on;
      logic [1:0] pos_reply, neg_reply;
      logic [5:0] entry;
      logic [2:0] side, nxt;
      bit         made;
      remote    = (verb == V_WILL) || (verb == V_WONT);
      want_on   = (verb == V_DO) || (verb == V_WILL);
      pos_reply = remote ? V_DO : V_WILL;
      neg_reply = remote ? V_DONT : V_WONT;
      res       = '0;
      res.kind  = OUT_REPLY;
      res.opt   = opt;
      made      = 1'b0;
      if (int'(opt) >= OPTION_COUNT) begin
         res.verb = neg_reply;
         return want_on;
      end
      entry = opt_state[opt];
      side  = remote ? entry[5:3] : entry[2:0];
      nxt   = side;
      case (side)
         S_YES: begin
            if (!want_on) begin
               nxt = S_NO;
               res.verb = neg_reply;
               made = 1'b1;
            end
         end
         S_NO: begin
            if (want_on) begin
               nxt = accept_q ? S_YES : S_NO;
               res.verb = accept_q ? pos_reply : neg_reply;
               made = 1'b1;
            end
         end
         S_WANTNO: nxt = S_NO;
         S_WANTNO_OPP: begin
            nxt = S_WANTYES;
            res.verb = pos_reply;
            made = 1'b1;
         end
         S_WANTYES: nxt = want_on ? S_YES : S_NO;
         S_WANTYES_OPP: begin
            nxt = want_on ? S_WANTNO : S_NO;
            if (want_on) begin
               res.verb = neg_reply;
               made = 1'b1;
            end
         end
         default: nxt = side;
      endcase
      if (remote)
         entry[5:3] = nxt;
      else
         entry[2:0] = nxt;
      opt_state[opt] = entry;
      return made;
   endfunction

   function automatic bit decode_byte(input logic [7:0] ch, output rx_result_type res);
      res = '0;
      case (parse_q)
         P_IAC: begin
            parse_q = P_DATA;
            case (ch)
               CMD_IAC: begin
                  res.kind = OUT_DATA;
                  res.data = ch;
                  return 1'b1;
               end
               CMD_DO: begin
                  verb_q = V_DO;
                  parse_q = P_VERB;
               end
               CMD_DONT: begin
                  verb_q = V_DONT;
                  parse_q = P_VERB;
               end
               CMD_WILL: begin
                  verb_q = V_WILL;
                  parse_q = P_VERB;
               end
               CMD_WONT: begin
                  verb_q = V_WONT;
                  parse_q = P_VERB;
               end
               CMD_SB: parse_q = P_SUB;
               default: parse_q = P_DATA;
            endcase
            return 1'b0;
         end
         P_VERB: begin
            parse_q = P_DATA;
            return run_option(verb_q, ch, res);
         end
         P_SUB: begin
            if (ch == CMD_IAC)
               parse_q = P_SUB_IAC;
            return 1'b0;
         end
         P_SUB_IAC: begin
            parse_q = (ch == CMD_SE) ? P_DATA : P_SUB;
            return 1'b0;
         end
         default: begin
            if (ch == CMD_IAC) begin
               parse_q = P_IAC;
               return 1'b0;
            end
            parse_q = P_DATA;
            res.kind = OUT_DATA;
            res.data = ch;
            return 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      rx_result_type want, got;
      bit            made;
      if (reset) begin
         expected_q.delete();
         parse_q  = P_DATA;
         verb_q   = V_DO;
         accept_q = 1'b0;
         foreach (opt_state[i])
            opt_state[i] = '0;
      end else begin
         if (csr_valid && csr_ready)
            accept_q = csr_accept_requests;
         if (req_valid && req_stall)
            stall_cycles++;
         if (req_valid && !req_stall) begin
            bytes_seen++;
            made = decode_byte(req_rx_byte, want);
            if (made)
               expected_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_kind, rsp_data_byte, rsp_reply_verb, rsp_reply_option};
            if (got.kind == OUT_REPLY)
               replies_seen++;
            else
               data_seen++;
            if (expected_q.size() == 0) begin
               report($sformatf("result %h with none expected", got));
            end else begin
               want = expected_q.pop_front();
               if (got.kind != want.kind)
                  report($sformatf("out_kind %0d, expected %0d", got.kind, want.kind));
               if (got.data != want.data)
                  report($sformatf("data_byte 0x%0h, expected 0x%0h", got.data, want.data));
               if (got.verb != want.verb)
                  report($sformatf("reply_verb %0d, expected %0d", got.verb, want.verb));
               if (got.opt != want.opt)
                  report($sformatf("reply_option %0d, expected %0d", got.opt, want.opt));
            end
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   import tro_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 281;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_chunk_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_out_kind;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_reply_verb;
   logic [7:0] rsp_reply_option;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_accept_requests = 1'b0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_ask = 0;
   int hold_left = 0;
   int held = 0;
   int sent = 0;
   int csr_writes = 0;
   int cycle_count = 0;
   int mismatches, outstanding, bytes_seen, data_seen, replies_seen, stall_cycles;

   telnet_rx_option_negotiator DUT (.*);

   telnet_rx_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte,
      .rsp_valid, .rsp_stall, .rsp_out_kind, .rsp_data_byte, .rsp_reply_verb,
      .rsp_reply_option, .csr_valid, .csr_ready, .csr_accept_requests,
      .mismatches, .outstanding, .bytes_seen, .data_seen, .replies_seen, .stall_cycles
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("Verification failed");
      $finish;
   end

   // receiver: random stall, or a long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
            held++;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input bit counted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_chunk_last <= 1'($urandom_range(1));
      do @(posedge clock); while (req_stall);
      if (counted)
         sent++;
   endtask

   // sender paused until every result is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_accept(input logic value);
      settle();
      csr_valid <= 1'b1;
      csr_accept_requests <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic send_random_sequence();
      int         pick, n;
      logic [7:0] cmd, opt;
      pick = $urandom_range(99);
      if (pick < 40) begin
         case ($urandom_range(3))
            0: cmd = CMD_DO;
            1: cmd = CMD_DONT;
            2: cmd = CMD_WILL;
            default: cmd = CMD_WONT;
         endcase
         opt = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
         push_byte(CMD_IAC, 1'b1);
         push_byte(cmd, 1'b1);
         push_byte(opt, 1'b1);
      end else if (pick < 70) begin
         push_byte(8'($urandom_range(254)), 1'b1);
      end else if (pick < 78) begin
         push_byte(CMD_IAC, 1'b1);
         push_byte(CMD_IAC, 1'b1);
      end else if (pick < 85) begin
         push_byte(CMD_IAC, 1'b1);
         push_byte(8'($urandom_range(255)), 1'b1);
      end else if (pick < 92) begin
         push_byte(CMD_IAC, 1'b1);
         push_byte(CMD_SB, 1'b1);
         n = $urandom_range(6);
         repeat (n) begin
            if ($urandom_range(5) == 0) begin
               push_byte(CMD_IAC, 1'b1);
               push_byte(8'($urandom_range(8'hF1, 8'hFF)), 1'b1);
            end else begin
               push_byte(8'($urandom_range(254)), 1'b1);
            end
         end
         push_byte(CMD_IAC, 1'b1);
         push_byte(CMD_SE, 1'b1);
      end else begin
         push_byte(8'($urandom_range(255)), 1'b1);
      end
   endtask

   initial begin
      int phase_start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: refusals first
      write_accept(1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFE, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(8'hF1, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_DO, 1'b1);
      push_byte(8'h01, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_DONT, 1'b1);
      push_byte(8'h00, 1'b1);
      // subnegotiation, IAC IAC inside keeps skipping
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_SB, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_SE, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_SE, 1'b1);
      // accepted enable, then disable from YES
      write_accept(1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_WILL, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(CMD_IAC, 1'b1);
      push_byte(CMD_WONT, 1'b1);
      push_byte(8'hFF, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         write_accept(1'(phase[0]));
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
         endcase
         phase_start = sent;
         while (sent - phase_start < PHASE_ITEMS) begin
            if (phase == 0 && hold_ask == 0 && held == 0 && sent - phase_start >= 100)
               hold_ask = 80;
            send_random_sequence();
         end
      end

      stall_pct = 0;
      settle();
      repeat (8) @(posedge clock);
      $display("run: %0d bytes accepted over four pacing phases, %0d register writes",
               bytes_seen, csr_writes);
      $display("run: %0d data bytes and %0d replies checked, input stalled %0d cycles",
               data_seen, replies_seen, stall_cycles);
      if (mismatches == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
